@@ rtl/fpsi_pkg.sv @@
// Shared types, angle constants and the quarter-wave table for the sine interpolator.
`default_nettype none
package fpsi_pkg;

  // Angle scale: two pi is FullAng
  localparam logic signed [15:0] QuarterAng = 16'sd3200;
  localparam logic signed [15:0] HalfAng    = 16'sd6399;
  localparam logic signed [15:0] ThreeQtrAng = 16'sd9599;
  localparam logic signed [15:0] FullAng    = 16'sd12799;

  // Segment math: step of 100 between table points
  localparam logic [11:0] SegStep    = 12'd100;
  localparam logic [4:0]  LastSeg    = 5'd31;
  // floor(f / 100) == (f * 1311) >> 17 for f in 0..3200
  localparam logic [22:0] SegRecip   = 23'd1311;
  // floor(x / 100) == (x * 5243) >> 19 for x in 0..10050
  localparam logic [26:0] RoundRecip = 27'd5243;
  localparam logic [13:0] HalfStep   = 14'd50;

  // Quarter-wave table, 33 points scaled by 2037
  localparam logic [10:0] QuarterWave [0:32] = '{
    11'd0,    11'd100,  11'd200,  11'd299,  11'd397,  11'd495,  11'd591,
    11'd686,  11'd780,  11'd871,  11'd960,  11'd1047, 11'd1132, 11'd1214,
    11'd1292, 11'd1368, 11'd1440, 11'd1509, 11'd1575, 11'd1636, 11'd1694,
    11'd1747, 11'd1797, 11'd1842, 11'd1882, 11'd1918, 11'd1949, 11'd1976,
    11'd1998, 11'd2015, 11'd2027, 11'd2035, 11'd2037
  };

  // Folded angle, split into segment and offset
  typedef struct packed {
    logic       valid;
    logic       in_range;
    logic       neg;
    logic [4:0] seg;
    logic [6:0] off;
  } fold_t;

  // Segment base value and the rounded slope product
  typedef struct packed {
    logic        valid;
    logic        in_range;
    logic        neg;
    logic [10:0] y1;
    logic [13:0] prod;
  } lerp_t;

endpackage
`default_nettype wire

@@ rtl/fixed_point_sine_interp.sv @@
// Top level of the fixed-point sine interpolator: input register and stage chain.
// One angle (12799 = two pi) is taken in every cycle in which start is high;
// busy is always low. Each angle gives one beat on done_o after passing
// through four register stages in order: input register, quadrant
// fold, table lookup with slope multiply, and reciprocal scaling into the result
// register. Results come out in order and must be taken when done_o is high.
// Angles outside -12799..12799 return sine_value_o = 0 with in_range_o low.
`default_nettype none
module fixed_point_sine_interp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic signed [15:0] angle_i,
  output logic              done_o,
  output logic signed [11:0] sine_value_o,
  output logic              in_range_o
);
  import fpsi_pkg::*;

  logic              in_valid_q;
  logic signed [15:0] angle_q;
  fold_t             fold;
  lerp_t             lerp;

  // Pipeline never stalls
  assign busy = 1'b0;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_i;
  end

  fpsi_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .angle_i (angle_q),
    .fold_o  (fold)
  );

  fpsi_lerp u_lerp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fold_i (fold),
    .lerp_o (lerp)
  );

  fpsi_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lerp_i       (lerp),
    .done_o       (done_o),
    .sine_value_o (sine_value_o),
    .in_range_o   (in_range_o)
  );

  // Every accepted angle shows up as a result beat
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 done_o)
    else $error("result beat missing after accepted angle");

  // No result beat without an accepted angle ahead of it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##4 done_o |-> $past(start && !busy, 4))
    else $error("result beat without accepted angle");

  // Out-of-range angles give zero
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !in_range_o) |-> (sine_value_o == 12'sd0))
    else $error("nonzero value for out-of-range angle");

  // Magnitude never exceeds full scale
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (sine_value_o <= 12'sd2037 && sine_value_o >= -12'sd2037))
    else $error("sine value beyond full scale");

  // An angle above the span is flagged out of range
  a_oor_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && angle_i > FullAng) |-> ##4 !in_range_o)
    else $error("out-of-range angle not flagged");

endmodule
`default_nettype wire

@@ rtl/fpsi_fold.sv @@
// Quadrant fold of the angle and split into table segment and offset.
`default_nettype none
module fpsi_fold (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic signed [15:0] angle_i,
  output fpsi_pkg::fold_t   fold_o
);
  import fpsi_pkg::*;

  logic              in_range;
  logic              q1, q2, q3;
  logic signed [15:0] u;
  logic signed [15:0] fs;
  logic [11:0]       f;
  logic [22:0]       sprod;
  logic [5:0]        seg_raw;
  logic [4:0]        seg;
  logic [11:0]       off_full;
  fold_t             fold_d, fold_q;

  // Range check and shift of negative angles into 0..12799
  always_comb begin
    in_range = (angle_i >= -FullAng) && (angle_i <= FullAng);
    u = (angle_i < 0) ? angle_i + FullAng : angle_i;
  end

  // Quadrant rules are picked on the signed angle
  always_comb begin
    q1 = (angle_i >= 0 && angle_i <= QuarterAng) || (angle_i <= -ThreeQtrAng);
    q2 = (angle_i > QuarterAng && angle_i <= HalfAng) ||
         (angle_i > -ThreeQtrAng && angle_i <= -HalfAng);
    q3 = (angle_i > HalfAng && angle_i <= ThreeQtrAng) ||
         (angle_i > -HalfAng && angle_i < -QuarterAng);
    if (q1) begin
      fs = u;
    end else if (q2) begin
      fs = HalfAng - u;
    end else if (q3) begin
      fs = u - HalfAng;
    end else begin
      fs = FullAng - u;
    end
  end

  // Clamp to 0..3200, then segment and offset
  always_comb begin
    if (fs < 0) begin
      f = 12'd0;
    end else if (fs > QuarterAng) begin
      f = QuarterAng[11:0];
    end else begin
      f = fs[11:0];
    end
    sprod    = {11'd0, f} * SegRecip;
    seg_raw  = sprod[22:17];
    seg      = (seg_raw > {1'b0, LastSeg}) ? LastSeg : seg_raw[4:0];
    off_full = f - ({7'd0, seg} * SegStep);

    fold_d.valid    = valid_i;
    fold_d.in_range = in_range;
    fold_d.neg      = !(q1 || q2);
    fold_d.seg      = seg;
    fold_d.off      = off_full[6:0];
  end

  // Stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q <= '0;
    end else begin
      fold_q <= fold_d;
    end
  end

  assign fold_o = fold_q;

endmodule
`default_nettype wire

@@ rtl/fpsi_lerp.sv @@
// Table lookup and slope times offset, with the rounding half step added.
`default_nettype none
module fpsi_lerp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fpsi_pkg::fold_t fold_i,
  output fpsi_pkg::lerp_t lerp_o
);
  import fpsi_pkg::*;

  logic [5:0]  idx_lo, idx_hi;
  logic [10:0] y1, y2;
  logic [6:0]  slope;
  lerp_t       lerp_d, lerp_q;

  // Both ends of the segment; seg never exceeds 31 so idx_hi stays in the table
  always_comb begin
    idx_lo = {1'b0, fold_i.seg};
    idx_hi = idx_lo + 6'd1;
    y1     = QuarterWave[idx_lo];
    y2     = QuarterWave[idx_hi];
    slope  = 7'(y2 - y1);

    lerp_d.valid    = fold_i.valid;
    lerp_d.in_range = fold_i.in_range;
    lerp_d.neg      = fold_i.neg;
    lerp_d.y1       = y1;
    lerp_d.prod     = (14'(slope) * 14'(fold_i.off)) + HalfStep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lerp_q <= '0;
    end else begin
      lerp_q <= lerp_d;
    end
  end

  assign lerp_o = lerp_q;

endmodule
`default_nettype wire

@@ rtl/fpsi_scale.sv @@
// Divide by the table step, add the segment base, apply sign; result register.
`default_nettype none
module fpsi_scale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fpsi_pkg::lerp_t   lerp_i,
  output logic              done_o,
  output logic signed [11:0] sine_value_o,
  output logic              in_range_o
);
  import fpsi_pkg::*;

  logic [26:0]       qprod;
  logic [6:0]        quot;
  logic [11:0]       mag;
  logic              done_q;
  logic signed [11:0] value_d, value_q;
  logic              in_range_q;

  // Reciprocal multiply replaces the divide by 100
  always_comb begin
    qprod = {13'd0, lerp_i.prod} * RoundRecip;
    quot  = qprod[25:19];
    mag   = {1'b0, lerp_i.y1} + {5'd0, quot};
    if (!lerp_i.in_range) begin
      value_d = 12'sd0;
    end else if (lerp_i.neg) begin
      value_d = -$signed(mag);
    end else begin
      value_d = $signed(mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= lerp_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    in_range_q <= lerp_i.in_range;
  end

  assign done_o       = done_q;
  assign sine_value_o = value_q;
  assign in_range_o   = in_range_q;

endmodule
`default_nettype wire
